>>> hdl/setq_pkg.sv
// Shared types and constants for the sorted event timer queue.
package setq_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam logic signed [31:0] INVALID_KIND = 32'sd0;

  typedef enum logic [2:0] {
    OP_INIT     = 3'd0,
    OP_SCHEDULE = 3'd1,
    OP_PEEK     = 3'd2,
    OP_POP      = 3'd3,
    OP_TICK     = 3'd4
  } setq_op_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_CLEAR  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_SHIFT  = 2'd3
  } setq_cell_cmd_t;

  typedef struct packed {
    logic        [31:0] fire_tick;
    logic signed [31:0] kind;
    logic signed [31:0] map_index;
    logic signed [31:0] map_x;
    logic signed [31:0] map_y;
    logic signed [31:0] cell_num;
    logic signed [31:0] aux_zero;
    logic signed [31:0] aux_one;
    logic signed [31:0] aux_two;
    logic signed [31:0] aux_three;
    logic signed [31:0] aux_four;
  } setq_entry_t;

  // Broadcast from the controller to every cell in the row.
  typedef struct packed {
    setq_cell_cmd_t cmd;
    setq_entry_t    new_entry;
  } setq_ctrl_t;

endpackage

>>> hdl/setq_if.sv
// Valid/ready channel interfaces for operation items and result items.
interface setq_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  op;
  logic        [31:0] tick_amount;
  logic signed [31:0] kind;
  logic signed [31:0] map_index;
  logic signed [31:0] map_x;
  logic signed [31:0] map_y;
  logic signed [31:0] cell_req;
  logic signed [31:0] aux_zero;
  logic signed [31:0] aux_one;
  logic signed [31:0] aux_two;
  logic signed [31:0] aux_three;
  logic signed [31:0] aux_four;

  modport source (output valid, op, tick_amount, kind, map_index, map_x, map_y, cell_req,
                  aux_zero, aux_one, aux_two, aux_three, aux_four, input ready);
  modport sink (input valid, op, tick_amount, kind, map_index, map_x, map_y, cell_req,
                aux_zero, aux_one, aux_two, aux_three, aux_four, output ready);
endinterface

interface setq_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic        [31:0] tick_out;
  logic signed [31:0] kind_out;
  logic signed [31:0] map_index_out;
  logic signed [31:0] map_x_out;
  logic signed [31:0] map_y_out;
  logic signed [31:0] cell_out;
  logic signed [31:0] aux_zero_out;
  logic signed [31:0] aux_one_out;
  logic signed [31:0] aux_two_out;
  logic signed [31:0] aux_three_out;
  logic signed [31:0] aux_four_out;

  modport source (output valid, ok, tick_out, kind_out, map_index_out, map_x_out, map_y_out,
                  cell_out, aux_zero_out, aux_one_out, aux_two_out, aux_three_out,
                  aux_four_out, input ready);
  modport sink (input valid, ok, tick_out, kind_out, map_index_out, map_x_out, map_y_out,
                cell_out, aux_zero_out, aux_one_out, aux_two_out, aux_three_out,
                aux_four_out, output ready);
endinterface

>>> hdl/setq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbours.
module setq_cell
  import setq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  setq_ctrl_t  ctrl,
  input  setq_entry_t left_entry,
  input  logic        left_valid,
  input  logic        left_push,
  input  setq_entry_t right_entry,
  input  logic        right_valid,
  output setq_entry_t entry,
  output logic        valid,
  output logic        push
);

  setq_entry_t entry_r, entry_nxt;
  logic        valid_r, valid_nxt;

  // New key lands here or earlier: slot is free or holds a later tick.
  assign push = !valid_r || (entry_r.fire_tick > ctrl.new_entry.fire_tick);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    unique case (ctrl.cmd)
      CELL_HOLD: begin
      end
      CELL_CLEAR: begin
        valid_nxt = 1'b0;
      end
      CELL_INSERT: begin
        if (push) begin
          if (left_push) begin
            entry_nxt = left_entry;
            valid_nxt = left_valid;
          end else begin
            entry_nxt = ctrl.new_entry;
            valid_nxt = 1'b1;
          end
        end
      end
      CELL_SHIFT: begin
        entry_nxt = right_entry;
        valid_nxt = right_valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

>>> hdl/sorted_event_timer_queue_top.sv
// Top level of the sorted event timer queue: controller, cell row and result register.
//
//   channel   direction  handshake          payload
//   in_if     sink       valid / ready      op, tick_amount, event words
//   out_if    source     valid / ready      ok, tick_out, head event words
//
// Every cell compares and shifts at once, so the row accepts one operation
// per clock while the result register can drain.
// A result appears in out_if in the cycle after its item is accepted.
// in_if.ready drops only while a result is held and out_if.ready is low.
// Reset (rst_n low, synchronous) empties the row and zeroes the current tick.
module sorted_event_timer_queue_top
  import setq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  setq_in_if.sink    in_if,
  setq_out_if.source out_if
);

  setq_entry_t          entry_w [CAPACITY];
  logic  [CAPACITY-1:0] valid_vec;
  logic  [CAPACITY-1:0] push_vec;
  setq_ctrl_t           ctrl;

  logic        in_accept;
  logic        full;
  logic        empty;
  setq_op_t    op;

  logic [31:0] current_tick_r, current_tick_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic               ok_r,            ok_nxt;
  logic        [31:0] tick_out_r,      tick_out_nxt;
  setq_entry_t        res_r,           res_nxt;

  // Take a new item whenever the result register is free or being drained.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_accept   = in_if.valid && in_if.ready;

  // Valid bits form a prefix of the row, so the ends tell full and empty.
  assign full  = valid_vec[CAPACITY-1];
  assign empty = !valid_vec[0];
  assign op    = setq_op_t'(in_if.op);

  // Broadcast command and candidate entry to the row.
  always_comb begin
    ctrl.cmd                 = CELL_HOLD;
    ctrl.new_entry.fire_tick = in_if.tick_amount;
    ctrl.new_entry.kind      = in_if.kind;
    ctrl.new_entry.map_index = in_if.map_index;
    ctrl.new_entry.map_x     = in_if.map_x;
    ctrl.new_entry.map_y     = in_if.map_y;
    ctrl.new_entry.cell_num  = in_if.cell_req;
    ctrl.new_entry.aux_zero  = in_if.aux_zero;
    ctrl.new_entry.aux_one   = in_if.aux_one;
    ctrl.new_entry.aux_two   = in_if.aux_two;
    ctrl.new_entry.aux_three = in_if.aux_three;
    ctrl.new_entry.aux_four  = in_if.aux_four;
    if (in_accept) begin
      unique case (op)
        OP_INIT:     ctrl.cmd = CELL_CLEAR;
        OP_SCHEDULE: ctrl.cmd = full ? CELL_HOLD : CELL_INSERT;
        OP_POP:      ctrl.cmd = empty ? CELL_HOLD : CELL_SHIFT;
        default:     ctrl.cmd = CELL_HOLD;
      endcase
    end
  end

  // Row of cells; each one sees the slot ahead (left) and behind (right).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    setq_entry_t left_entry, right_entry;
    logic        left_valid, left_push, right_valid;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_valid = 1'b0;
      assign left_push  = 1'b0;
    end else begin : g_mid
      assign left_entry = entry_w[i-1];
      assign left_valid = valid_vec[i-1];
      assign left_push  = push_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_entry = entry_w[i+1];
      assign right_valid = valid_vec[i+1];
    end

    setq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_entry  (left_entry),
      .left_valid  (left_valid),
      .left_push   (left_push),
      .right_entry (right_entry),
      .right_valid (right_valid),
      .entry       (entry_w[i]),
      .valid       (valid_vec[i]),
      .push        (push_vec[i])
    );
  end

  // Build the result and load or advance the current tick.
  always_comb begin
    current_tick_nxt = current_tick_r;
    ok_nxt           = 1'b0;
    tick_out_nxt     = '0;
    res_nxt          = '0;
    unique case (op)
      OP_INIT: begin
        current_tick_nxt = in_if.tick_amount;
        ok_nxt           = 1'b1;
      end
      OP_SCHEDULE: begin
        ok_nxt = !full;
      end
      OP_PEEK, OP_POP: begin
        if (empty) begin
          res_nxt.kind = INVALID_KIND;
        end else begin
          ok_nxt       = 1'b1;
          tick_out_nxt = entry_w[0].fire_tick;
          res_nxt      = entry_w[0];
        end
      end
      OP_TICK: begin
        current_tick_nxt = current_tick_r + in_if.tick_amount;
        ok_nxt           = 1'b1;
        tick_out_nxt     = current_tick_nxt;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      current_tick_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        current_tick_r <= current_tick_nxt;
      end
    end
  end

  // Hold the result payload until the next accepted item.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ok_r       <= ok_nxt;
      tick_out_r <= tick_out_nxt;
      res_r      <= res_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.ok            = ok_r;
  assign out_if.tick_out      = tick_out_r;
  assign out_if.kind_out      = res_r.kind;
  assign out_if.map_index_out = res_r.map_index;
  assign out_if.map_x_out     = res_r.map_x;
  assign out_if.map_y_out     = res_r.map_y;
  assign out_if.cell_out      = res_r.cell_num;
  assign out_if.aux_zero_out  = res_r.aux_zero;
  assign out_if.aux_one_out   = res_r.aux_one;
  assign out_if.aux_two_out   = res_r.aux_two;
  assign out_if.aux_three_out = res_r.aux_three;
  assign out_if.aux_four_out  = res_r.aux_four;

`ifndef NO_ASSERTIONS
  logic [CAPACITY-1:0] valid_inc;
  assign valid_inc = valid_vec + CAPACITY'(1);

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_inc & valid_vec) == '0)
    else $error("queue occupancy is not a prefix of the row");

  a_init_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && op == OP_INIT) |=> !valid_vec[0])
    else $error("init left an entry at the head");

  a_schedule_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && op == OP_SCHEDULE && !full) |=> valid_vec[0])
    else $error("schedule left the head empty");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted item produced no result");
`endif

endmodule
